/* design/dcpm_pkg.sv */
`timescale 1ns / 1ps
// Package for the depth-to-color pixel map unit.
// Holds register indexes, reset values and fixed widths; no dependencies.
package dcpm_pkg;

    // Register indexes on the configuration port.
    localparam logic [3:0] CFG_M00_M01 = 4'd0;
    localparam logic [3:0] CFG_M02_M10 = 4'd1;
    localparam logic [3:0] CFG_M11_M12 = 4'd2;
    localparam logic [3:0] CFG_M20_M21 = 4'd3;
    localparam logic [3:0] CFG_M22_T0  = 4'd4;
    localparam logic [3:0] CFG_T1_T2   = 4'd5;
    localparam logic [3:0] CFG_WIDTH   = 4'd6;
    localparam logic [3:0] CFG_HEIGHT  = 4'd7;

    localparam int CFG_IDX_BITS = 4;
    localparam int CFG_DATA_BITS = 64;
    localparam int DIM_BITS = 13;
    localparam int DEPTH_BITS = 16;
    localparam int Q_BITS = 12;
    localparam int INDEX_BITS = 24;
    localparam int DEFAULT_COORD_BITS = 10;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 13'd1920;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 13'd1080;
    localparam logic [DIM_BITS-1:0] FRAME_MAX    = 13'd4096;

    localparam logic [DEPTH_BITS-1:0] DEPTH_NONE = 16'h0000;
    localparam logic [DEPTH_BITS-1:0] DEPTH_SAT  = 16'hFFFF;

    typedef logic signed [31:0] t_coef;

    // Clamp a frame dimension to the largest supported frame.
    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
        clamp_dim = (v > FRAME_MAX) ? FRAME_MAX : v;
    endfunction

endpackage

/* design/depth_to_color_pixel_map_unit.sv */
`timescale 1ns / 1ps
// Top level of the depth-to-color pixel map unit: projection, two pipelined
// dividers and the color index. Depends on dcpm_pkg.
//
//   channel   direction  handshake                    beat
//   input     in         i_in_valid / o_in_stall      col, row, depth
//   output    out        o_out_valid / i_out_stall    valid, x, y, index
//   config    in         i_cfg_valid / o_cfg_ready    index, data
//
// One pixel enters every clock while the output is not stalled. The pipeline
// has four projection stages, two sign/bound stages, twelve one-bit divider
// stages and two stages for the frame check and index.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults. A stall on a valid output beat freezes the whole pipeline and
// is passed back to the input in the same cycle; nothing is lost or repeated.
module depth_to_color_pixel_map_unit #(
    parameter int COORD_BITS = dcpm_pkg::DEFAULT_COORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dcpm_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [dcpm_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [COORD_BITS-1:0]               i_pixel_col,
    input  logic [COORD_BITS-1:0]               i_pixel_row,
    input  logic [dcpm_pkg::DEPTH_BITS-1:0]     i_depth_raw,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_map_valid,
    output logic [dcpm_pkg::Q_BITS-1:0]         o_color_x,
    output logic [dcpm_pkg::Q_BITS-1:0]         o_color_y,
    output logic [dcpm_pkg::INDEX_BITS-1:0]     o_color_index
);
    import dcpm_pkg::*;

    localparam int PW = 33 + COORD_BITS;   // coefficient times coordinate
    localparam int LW = PW + 2;            // row sum
    localparam int DW = LW + 17;           // depth times row sum
    localparam int AW = 63;                // magnitude of a numerator
    localparam int SW = AW + Q_BITS;       // shifted denominator
    localparam int NS = Q_BITS;            // divider stages

    // Configuration registers.
    logic [63:0] r_m00_m01, r_m02_m10, r_m11_m12, r_m20_m21, r_m22_t0, r_t1_t2;
    logic [DIM_BITS-1:0] r_width, r_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m00_m01 <= '0;
            r_m02_m10 <= '0;
            r_m11_m12 <= '0;
            r_m20_m21 <= '0;
            r_m22_t0  <= '0;
            r_t1_t2   <= '0;
            r_width   <= WIDTH_RESET;
            r_height  <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_M00_M01: r_m00_m01 <= i_cfg_data;
                CFG_M02_M10: r_m02_m10 <= i_cfg_data;
                CFG_M11_M12: r_m11_m12 <= i_cfg_data;
                CFG_M20_M21: r_m20_m21 <= i_cfg_data;
                CFG_M22_T0:  r_m22_t0  <= i_cfg_data;
                CFG_T1_T2:   r_t1_t2   <= i_cfg_data;
                CFG_WIDTH:   r_width   <= i_cfg_data[DIM_BITS-1:0];
                CFG_HEIGHT:  r_height  <= i_cfg_data[DIM_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Unpack coefficients.
    t_coef m_c [3];
    t_coef m_r [3];
    t_coef m_k [3];
    t_coef t_v [3];
    logic [DIM_BITS-1:0] frame_w, frame_h;

    always_comb begin
        m_c[0] = t_coef'(r_m00_m01[63:32]);
        m_r[0] = t_coef'(r_m00_m01[31:0]);
        m_k[0] = t_coef'(r_m02_m10[63:32]);
        m_c[1] = t_coef'(r_m02_m10[31:0]);
        m_r[1] = t_coef'(r_m11_m12[63:32]);
        m_k[1] = t_coef'(r_m11_m12[31:0]);
        m_c[2] = t_coef'(r_m20_m21[63:32]);
        m_r[2] = t_coef'(r_m20_m21[31:0]);
        m_k[2] = t_coef'(r_m22_t0[63:32]);
        t_v[0] = t_coef'(r_m22_t0[31:0]);
        t_v[1] = t_coef'(r_t1_t2[63:32]);
        t_v[2] = t_coef'(r_t1_t2[31:0]);
        frame_w = clamp_dim(r_width);
        frame_h = clamp_dim(r_height);
    end

    // Pipeline advance: the whole pipe moves unless a held result is stalled.
    logic en;
    assign en = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // Stage 1: coefficient times column and row.
    logic r1_v, r1_ok;
    logic [DEPTH_BITS-1:0] r1_d;
    logic signed [PW-1:0] r1_pc [3];
    logic signed [PW-1:0] r1_pr [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ok <= (i_depth_raw != DEPTH_NONE) && (i_depth_raw != DEPTH_SAT);
            r1_d  <= i_depth_raw;
            for (int k = 0; k < 3; k++) begin
                r1_pc[k] <= PW'(m_c[k]) * PW'($signed({1'b0, i_pixel_col}));
                r1_pr[k] <= PW'(m_r[k]) * PW'($signed({1'b0, i_pixel_row}));
            end
        end
    end

    // Stage 2: row sums.
    logic r2_v, r2_ok;
    logic [DEPTH_BITS-1:0] r2_d;
    logic signed [LW-1:0] r2_lin [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ok <= r1_ok;
            r2_d  <= r1_d;
            for (int k = 0; k < 3; k++) begin
                r2_lin[k] <= LW'(r1_pc[k]) + LW'(r1_pr[k]) + LW'(m_k[k]);
            end
        end
    end

    // Stage 3: depth times row sum.
    logic r3_v, r3_ok;
    logic signed [DW-1:0] r3_pd [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ok <= r2_ok;
            for (int k = 0; k < 3; k++) begin
                r3_pd[k] <= DW'(r2_lin[k]) * DW'($signed({1'b0, r2_d}));
            end
        end
    end

    // Stage 4: add the translation, scaled to the Q.20 grid.
    logic r4_v, r4_ok;
    logic signed [63:0] r4_s [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_ok <= r3_ok;
            for (int k = 0; k < 3; k++) begin
                r4_s[k] <= 64'(r3_pd[k]) + (64'(t_v[k]) <<< 8);
            end
        end
    end

    // Stage 5: magnitudes, signs and the denominator check.
    logic r5_v, r5_ok, r5_nx, r5_ny;
    logic [AW-1:0] r5_ax, r5_ay, r5_den;
    logic signed [63:0] neg_x, neg_y;

    assign neg_x = -r4_s[0];
    assign neg_y = -r4_s[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_ok  <= r4_ok && (r4_s[2] > 64'sd0);
            r5_nx  <= r4_s[0][63];
            r5_ny  <= r4_s[1][63];
            r5_ax  <= r4_s[0][63] ? neg_x[AW-1:0] : r4_s[0][AW-1:0];
            r5_ay  <= r4_s[1][63] ? neg_y[AW-1:0] : r4_s[1][AW-1:0];
            r5_den <= r4_s[2][AW-1:0];
        end
    end

    // Stage 6: reject quotients of -1 or less, or too large for the 12-bit quotient.
    logic ov_x, ov_y;
    logic r6_v, r6_ok;
    logic [AW-1:0] r6_ax, r6_ay, r6_den;

    always_comb begin
        ov_x = r5_nx ? (r5_ax >= r5_den)
                     : ({{Q_BITS{1'b0}}, r5_ax} >= {r5_den, {Q_BITS{1'b0}}});
        ov_y = r5_ny ? (r5_ay >= r5_den)
                     : ({{Q_BITS{1'b0}}, r5_ay} >= {r5_den, {Q_BITS{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_ok  <= r5_ok && !ov_x && !ov_y;
            r6_ax  <= r5_ax;
            r6_ay  <= r5_ay;
            r6_den <= r5_den;
        end
    end

    // Divider stages: one quotient bit per stage, most significant first.
    logic              r_dv_v   [NS];
    logic              r_dv_ok  [NS];
    logic [AW-1:0]     r_dv_rx  [NS];
    logic [AW-1:0]     r_dv_ry  [NS];
    logic [AW-1:0]     r_dv_den [NS];
    logic [Q_BITS-1:0] r_dv_qx  [NS];
    logic [Q_BITS-1:0] r_dv_qy  [NS];

    logic              dv_v_in   [NS];
    logic              dv_ok_in  [NS];
    logic [AW-1:0]     dv_rx_in  [NS];
    logic [AW-1:0]     dv_ry_in  [NS];
    logic [AW-1:0]     dv_den_in [NS];
    logic [Q_BITS-1:0] dv_qx_in  [NS];
    logic [Q_BITS-1:0] dv_qy_in  [NS];

    logic [AW-1:0]     n_dv_rx  [NS];
    logic [AW-1:0]     n_dv_ry  [NS];
    logic [Q_BITS-1:0] n_dv_qx  [NS];
    logic [Q_BITS-1:0] n_dv_qy  [NS];

    always_comb begin
        dv_v_in[0]   = r6_v;
        dv_ok_in[0]  = r6_ok;
        dv_rx_in[0]  = r6_ax;
        dv_ry_in[0]  = r6_ay;
        dv_den_in[0] = r6_den;
        dv_qx_in[0]  = '0;
        dv_qy_in[0]  = '0;
        for (int j = 1; j < NS; j++) begin
            dv_v_in[j]   = r_dv_v[j-1];
            dv_ok_in[j]  = r_dv_ok[j-1];
            dv_rx_in[j]  = r_dv_rx[j-1];
            dv_ry_in[j]  = r_dv_ry[j-1];
            dv_den_in[j] = r_dv_den[j-1];
            dv_qx_in[j]  = r_dv_qx[j-1];
            dv_qy_in[j]  = r_dv_qy[j-1];
        end
    end

    always_comb begin
        for (int j = 0; j < NS; j++) begin
            logic [SW-1:0] dsh;
            logic          bx, by;
            dsh = {{Q_BITS{1'b0}}, dv_den_in[j]} << (NS - 1 - j);
            bx  = {{Q_BITS{1'b0}}, dv_rx_in[j]} >= dsh;
            by  = {{Q_BITS{1'b0}}, dv_ry_in[j]} >= dsh;
            n_dv_rx[j] = bx ? dv_rx_in[j] - dsh[AW-1:0] : dv_rx_in[j];
            n_dv_ry[j] = by ? dv_ry_in[j] - dsh[AW-1:0] : dv_ry_in[j];
            n_dv_qx[j] = {dv_qx_in[j][Q_BITS-2:0], bx};
            n_dv_qy[j] = {dv_qy_in[j][Q_BITS-2:0], by};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NS; j++) begin
                r_dv_v[j] <= 1'b0;
            end
        end else if (en) begin
            for (int j = 0; j < NS; j++) begin
                r_dv_v[j] <= dv_v_in[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < NS; j++) begin
                r_dv_ok[j]  <= dv_ok_in[j];
                r_dv_den[j] <= dv_den_in[j];
                r_dv_rx[j]  <= n_dv_rx[j];
                r_dv_ry[j]  <= n_dv_ry[j];
                r_dv_qx[j]  <= n_dv_qx[j];
                r_dv_qy[j]  <= n_dv_qy[j];
            end
        end
    end

    // Frame check and row offset.
    logic r7_v, r7_ok;
    logic [Q_BITS-1:0] r7_x, r7_y;
    logic [INDEX_BITS:0] r7_row;
    logic [Q_BITS-1:0] q_x, q_y;

    assign q_x = r_dv_qx[NS-1];
    assign q_y = r_dv_qy[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r_dv_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_ok  <= r_dv_ok[NS-1] && ({1'b0, q_x} < frame_w) && ({1'b0, q_y} < frame_h);
            r7_x   <= q_x;
            r7_y   <= q_y;
            r7_row <= (INDEX_BITS+1)'(q_y) * (INDEX_BITS+1)'(frame_w);
        end
    end

    // Output register: invalid beats carry zero fields.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_map_valid   <= r7_ok;
            o_color_x     <= r7_ok ? r7_x : '0;
            o_color_y     <= r7_ok ? r7_y : '0;
            o_color_index <= r7_ok ? INDEX_BITS'(r7_row + (INDEX_BITS+1)'(r7_x)) : '0;
        end
    end

    // A rejected pixel never carries an x coordinate or an index.
    a_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_map_valid) |-> (o_color_x == '0 && o_color_index == '0))
        else $error("invalid beat carries nonzero fields");

    // A mapped point lies inside the frame.
    a_inside_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_map_valid) |-> ({1'b0, o_color_x} < frame_w
                                          && {1'b0, o_color_y} < frame_h))
        else $error("mapped point outside frame");

    // A stalled output holds the pipeline tail in place.
    a_tail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(r7_v) && $stable(r7_x)))
        else $error("pipeline moved under stall");

endmodule

/* tb/sv/depth_to_color_pixel_map_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench for the depth-to-color pixel map unit: directed table plus random
// pixels, checked against an in-bench fixed-point projection. Depends on dcpm_pkg.
module depth_to_color_pixel_map_unit_tb;
    import dcpm_pkg::*;

    localparam int CB = DEFAULT_COORD_BITS;
    localparam int IDLE_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic        ok;
        logic [11:0] x;
        logic [11:0] y;
        logic [23:0] idx;
    } map_t;

    typedef struct {
        logic [CB-1:0] col;
        logic [CB-1:0] row;
        logic [15:0]   depth;
        logic          typed;
        map_t          want;
    } pix_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [CB-1:0] pix_col = '0;
    logic [CB-1:0] pix_row = '0;
    logic [15:0] depth_raw = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic map_valid;
    logic [11:0] color_x;
    logic [11:0] color_y;
    logic [23:0] color_index;

    // Shadow copy of the registers.
    logic [63:0] proj_regs [0:5];
    logic [12:0] frame_w;
    logic [12:0] frame_h;

    map_t expected_maps [$];
    int mismatches = 0;
    int quiet_cycles = 0;
    bit stim_done = 1'b0;
    bit hold_off = 1'b0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    depth_to_color_pixel_map_unit #(.COORD_BITS(CB)) DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_pixel_col(pix_col), .i_pixel_row(pix_row), .i_depth_raw(depth_raw),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_map_valid(map_valid), .o_color_x(color_x), .o_color_y(color_y),
        .o_color_index(color_index)
    );

    function automatic longint word_of(logic [63:0] v, bit high);
        logic signed [31:0] w;
        w = high ? v[63:32] : v[31:0];
        return longint'(w);
    endfunction

    // Project one depth pixel into the color frame.
    function automatic map_t project_pixel(logic [CB-1:0] col, logic [CB-1:0] row,
                                           logic [15:0] depth);
        map_t res;
        longint m [9];
        longint t [3];
        longint s [3];
        longint x, y, w, h;
        res = '0;
        w = (frame_w > FRAME_MAX) ? 4096 : longint'(frame_w);
        h = (frame_h > FRAME_MAX) ? 4096 : longint'(frame_h);
        if (depth == DEPTH_NONE || depth == DEPTH_SAT) return res;
        for (int k = 0; k < 5; k++) begin
            m[2*k] = word_of(proj_regs[k], 1'b1);
            if (k < 4) m[2*k+1] = word_of(proj_regs[k], 1'b0);
        end
        t[0] = word_of(proj_regs[4], 1'b0);
        t[1] = word_of(proj_regs[5], 1'b1);
        t[2] = word_of(proj_regs[5], 1'b0);
        for (int k = 0; k < 3; k++)
            s[k] = longint'(depth) * (m[3*k] * longint'(col) + m[3*k+1] * longint'(row)
                   + m[3*k+2]) + t[k] * 256;
        if (s[2] <= 0) return res;
        x = s[0] / s[2];
        y = s[1] / s[2];
        if (x < 0 || y < 0 || x >= w || y >= h) return res;
        res.ok = 1'b1;
        res.x = x[11:0];
        res.y = y[11:0];
        res.idx = 24'(y * w + x);
        return res;
    endfunction

    // One register write, done only while the pipeline is empty.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx < CFG_WIDTH) proj_regs[idx] = data;
        else if (idx == CFG_WIDTH) frame_w = data[12:0];
        else frame_h = data[12:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering pixels and wait for every queued result.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_maps.size() != 0) @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    // Send one pixel beat; the expectation is queued at acceptance.
    // Valid stays high after the beat so that a zero gap gives back-to-back beats.
    task automatic send_pixel(logic [CB-1:0] col, logic [CB-1:0] row, logic [15:0] depth,
                              bit typed, map_t want, int gap);
        map_t pred;
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        pix_col <= col;
        pix_row <= row;
        depth_raw <= depth;
        do @(posedge clk); while (in_stall);
        pred = project_pixel(col, row, depth);
        if (typed && pred != want)
            $display("table row disagrees with projection: col %0d row %0d", col, row);
        expected_maps.push_back(typed ? want : pred);
    endtask

    // Typical camera setup: diagonal-ish matrix near a real calibration.
    task automatic load_camera(bit wide);
        write_reg(CFG_M00_M01, {32'sd1 <<< 20, 32'sd0});
        write_reg(CFG_M02_M10, {-32'sd100 <<< 20, 32'sd0});
        write_reg(CFG_M11_M12, {32'sd1 <<< 20, -32'sd50 <<< 20});
        write_reg(CFG_M20_M21, {32'sd0, 32'sd0});
        write_reg(CFG_M22_T0, {32'sd1 <<< 20, $urandom_range(0, 4096) - 2048});
        write_reg(CFG_T1_T2, {32'($urandom_range(0, 4096)) - 32'sd2048,
                              32'($urandom_range(0, 256))});
        write_reg(CFG_WIDTH, 64'(wide ? 13'd4096 : 13'($urandom_range(200, 1920))));
        write_reg(CFG_HEIGHT, 64'(wide ? 13'd4096 : 13'($urandom_range(200, 1080))));
    endtask

    task automatic random_pixels(int count);
        logic [15:0] d;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0: d = DEPTH_NONE;
                1: d = DEPTH_SAT;
                2: d = 16'($urandom);
                default: d = 16'($urandom_range(1, 4000));
            endcase
            send_pixel(CB'($urandom), CB'($urandom), d, 1'b0, '0,
                       ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7));
        end
    endtask

    // Directed table; expected values typed in for reset state and no-depth rows.
    pix_row_t directed [] = '{
        '{CB'(0), CB'(0), 16'h0000, 1'b1, '0},
        '{CB'(1023), CB'(1023), 16'hFFFF, 1'b1, '0},
        '{CB'(512), CB'(256), 16'd1000, 1'b1, '0},
        '{CB'(0), CB'(0), 16'd1, 1'b0, '0},
        '{CB'(1023), CB'(0), 16'd65534, 1'b0, '0},
        '{CB'(0), CB'(1023), 16'd32768, 1'b0, '0},
        '{CB'(100), CB'(100), 16'd1, 1'b0, '0},
        '{CB'(150), CB'(80), 16'd2000, 1'b0, '0},
        '{CB'(1023), CB'(1023), 16'd1, 1'b0, '0},
        '{CB'(10), CB'(10), 16'd500, 1'b0, '0},
        '{CB'(99), CB'(49), 16'd700, 1'b0, '0},
        '{CB'(341), CB'(682), 16'h5555, 1'b0, '0},
        '{CB'(682), CB'(341), 16'hAAAA, 1'b0, '0},
        '{CB'(0), CB'(0), 16'h0000, 1'b1, '0}
    };

    // Stimulus and configuration phases.
    initial begin
        proj_regs = '{default: '0};
        frame_w = WIDTH_RESET;
        frame_h = HEIGHT_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset registers: zero matrix makes every pixel invalid.
        foreach (directed[i])
            if (directed[i].typed)
                send_pixel(directed[i].col, directed[i].row, directed[i].depth, 1'b1,
                           directed[i].want, 0);
        drain();

        // Camera setup with a small frame, then walk the table again; only the
        // no-depth rows keep their typed result under a loaded matrix.
        load_camera(1'b0);
        foreach (directed[i])
            send_pixel(directed[i].col, directed[i].row, directed[i].depth,
                       directed[i].typed && (directed[i].depth == DEPTH_NONE
                                             || directed[i].depth == DEPTH_SAT),
                       directed[i].want, $urandom_range(0, 2));
        // Receiver holds off for a long stretch while pixels keep coming.
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 40; i++)
                send_pixel(CB'($urandom), CB'($urandom), 16'($urandom_range(1, 3000)),
                           1'b0, '0, 0);
        join
        random_pixels(80);
        drain();

        // Largest frame, then the smallest one.
        load_camera(1'b1);
        random_pixels(80);
        drain();
        write_reg(CFG_WIDTH, 64'd1);
        write_reg(CFG_HEIGHT, 64'd1);
        write_reg(CFG_M22_T0, {32'sd1 <<< 20, 32'sd0});
        random_pixels(30);
        drain();

        // Zero-sized and oversized frames, odd matrices.
        write_reg(CFG_WIDTH, 64'd0);
        write_reg(CFG_HEIGHT, 64'h1FFF);
        random_pixels(20);
        drain();
        for (int p = 0; p < 4; p++) begin
            for (int k = 0; k < 6; k++)
                write_reg(CFG_IDX_BITS'(k), {$urandom, $urandom});
            write_reg(CFG_WIDTH, 64'(13'($urandom)));
            write_reg(CFG_HEIGHT, 64'(13'($urandom)));
            random_pixels(15);
            drain();
        end
        write_reg(CFG_M00_M01, 64'h7FFFFFFF_80000000);
        write_reg(CFG_M20_M21, 64'h80000000_7FFFFFFF);
        write_reg(CFG_M22_T0, 64'h7FFFFFFF_7FFFFFFF);
        write_reg(CFG_T1_T2, 64'h80000000_80000000);
        write_reg(CFG_WIDTH, 64'd4096);
        write_reg(CFG_HEIGHT, 64'd4096);
        random_pixels(30);
        drain();
        load_camera(1'b0);
        random_pixels(60);
        drain();
        stim_done = 1'b1;
    end

    // Receiver stall: random per beat, plus the long hold-off.
    initial begin
        int wait_cycles;
        forever begin
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            @(negedge clk);
            if (wait_cycles > 0 || hold_off) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
                while (hold_off) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Result checker and watchdog.
    always @(posedge clk) begin
        map_t got;
        map_t want;
        got = '{map_valid, color_x, color_y, color_index};
        if (rst_n && out_valid && !out_stall) begin
            if (expected_maps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat: %p", got);
            end else begin
                want = expected_maps.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: want ok %0d x %0d y %0d idx %0d, ",
                                  "got ok %0d x %0d y %0d idx %0d"},
                                 want.ok, want.x, want.y, want.idx,
                                 got.ok, got.x, got.y, got.idx);
                end
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || (expected_maps.size() == 0 && !in_valid && !cfg_valid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (stim_done || quiet_cycles >= WATCHDOG_LIMIT);
        if (!stim_done) begin
            $display("FAIL");
        end else if (mismatches == 0 && expected_maps.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
